// ===== rtl/sfts_pkg.sv =====
// Package for the SPI flash transfer sequencer: sizes, codes and the
// transaction structs shared by the input stage, the core and the top level.
// No dependencies.
package sfts_pkg;

    localparam int PAGE_BYTES     = 256;
    localparam int ADDRESS_BITS   = 24;
    localparam int MAX_READ_BYTES = 65535;

    localparam int PAGE_BITS = $clog2(PAGE_BYTES);
    localparam int CHUNK_W   = PAGE_BITS + 1;
    localparam int SPACE_W   = 34;

    localparam int CMD_W     = 3;
    localparam int FADDR_W   = 24;
    localparam int COUNT_W   = 25;
    localparam int BADDR_W   = 32;
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int LEN_W     = 16;
    localparam int PHASE_W   = 4;
    localparam int ACTION_W  = 3;

    localparam logic [SPACE_W-1:0] ADDR_SPACE = SPACE_W'(1) << ADDRESS_BITS;
    localparam logic [COUNT_W-1:0] MAX_READ   = COUNT_W'(MAX_READ_BYTES);
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd1000;

    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FAST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POLL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ABORT = 3'd4;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 4'd0,
        PH_WPEND     = 4'd1,
        PH_RPEND     = 4'd2,
        PH_FRPEND    = 4'd3,
        PH_WAITTX    = 4'd4,
        PH_WAITRX    = 4'd5,
        PH_WAITREADY = 4'd6,
        PH_DONE      = 4'd7,
        PH_ERROR     = 4'd8
    } t_phase;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_PROGRAM = 3'd1,
        ACT_READ    = 3'd2,
        ACT_FAST    = 3'd3,
        ACT_ABORT   = 3'd4
    } t_action;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FADDR_W-1:0] flash_address;
        logic [COUNT_W-1:0] byte_count;
        logic [BADDR_W-1:0] buffer_address;
        logic               flash_busy;
        logic               status_valid;
        logic               tx_busy;
        logic               rx_busy;
        logic [TIME_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic                accepted;
        logic [PHASE_W-1:0]  phase;
        logic [ACTION_W-1:0] action;
        logic [FADDR_W-1:0]  action_flash_address;
        logic [BADDR_W-1:0]  action_buffer_address;
        logic [LEN_W-1:0]    action_length;
        logic                done_res;
        logic                error;
    } t_result;

endpackage

// ===== rtl/sfts_in_stage.sv =====
// Input register of the SPI flash transfer sequencer: captures one event
// transaction and holds it until the core takes it. Depends on sfts_pkg.
module sfts_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sfts_pkg::t_item i_item,
    output logic           o_stall,
    input  logic           i_adv,
    output logic           o_valid,
    output sfts_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    sfts_pkg::t_item r_item;
    logic            load;

    // hold while full and the core cannot drain this cycle
    assign o_stall = r_valid && !i_adv;
    assign load    = i_valid && !o_stall;
    assign n_valid = load || (r_valid && !i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/sfts_core.sv =====
// Sequencer core: transfer state registers and the single-pass step logic
// that turns one event transaction into one result. Depends on sfts_pkg.
module sfts_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  sfts_pkg::t_item             i_item,
    input  logic [sfts_pkg::TMO_W-1:0]  i_wait_limit,
    output sfts_pkg::t_result           o_result
);

    sfts_pkg::t_phase                 r_phase,  n_phase;
    logic [sfts_pkg::COUNT_W-1:0]     r_cursor, n_cursor;
    logic [sfts_pkg::COUNT_W-1:0]     r_left,   n_left;
    logic [sfts_pkg::BADDR_W-1:0]     r_buf,    n_buf;
    logic [sfts_pkg::CHUNK_W-1:0]     r_chunk,  n_chunk;
    logic [sfts_pkg::TIME_W-1:0]      r_stamp,  n_stamp;

    logic                             active;
    logic                             not_ready;
    logic                             link_ready;
    logic                             range_ok;
    logic                             req_ok;
    logic [sfts_pkg::SPACE_W-1:0]     range_end;
    logic [sfts_pkg::TIME_W-1:0]      elapsed;
    logic                             timed_out;
    logic [sfts_pkg::COUNT_W-1:0]     step_bytes;

    assign active = (r_phase >= sfts_pkg::PH_WPEND) && (r_phase <= sfts_pkg::PH_WAITREADY);
    assign not_ready  = i_item.flash_busy || !i_item.status_valid;
    assign link_ready = !i_item.tx_busy && !i_item.rx_busy && !not_ready;

    assign range_end = sfts_pkg::SPACE_W'(i_item.flash_address)
                     + sfts_pkg::SPACE_W'(i_item.byte_count);
    assign range_ok  = (i_item.byte_count != '0)
                    && (sfts_pkg::SPACE_W'(i_item.flash_address) < sfts_pkg::ADDR_SPACE)
                    && (range_end <= sfts_pkg::ADDR_SPACE);
    assign req_ok = range_ok && !active
                 && ((i_item.command == sfts_pkg::CMD_WRITE)
                     || (i_item.byte_count <= sfts_pkg::MAX_READ));

    assign elapsed   = i_item.now_ms - r_stamp;
    assign timed_out = elapsed >= sfts_pkg::TIME_W'(i_wait_limit);

    // bytes the finished page program covered
    assign step_bytes = (sfts_pkg::COUNT_W'(r_chunk) > r_left) ? r_left
                                                               : sfts_pkg::COUNT_W'(r_chunk);

    always_comb begin
        logic                          do_chunk;
        logic                          do_read;
        logic                          do_tmo;
        logic                          do_error;
        sfts_pkg::t_action             read_act;
        sfts_pkg::t_action             act;
        logic [sfts_pkg::FADDR_W-1:0]  res_fa;
        logic [sfts_pkg::BADDR_W-1:0]  res_ba;
        logic [sfts_pkg::LEN_W-1:0]    res_len;
        logic                          acc;
        logic [sfts_pkg::CHUNK_W-1:0]  room;
        logic [sfts_pkg::CHUNK_W-1:0]  chunk;

        n_phase  = r_phase;
        n_cursor = r_cursor;
        n_left   = r_left;
        n_buf    = r_buf;
        n_chunk  = r_chunk;
        n_stamp  = r_stamp;
        do_chunk = 1'b0;
        do_read  = 1'b0;
        do_tmo   = 1'b0;
        do_error = 1'b0;
        read_act = sfts_pkg::ACT_READ;
        act      = sfts_pkg::ACT_NONE;
        res_fa   = '0;
        res_ba   = '0;
        res_len  = '0;
        acc      = 1'b0;
        room     = '0;
        chunk    = '0;

        unique case (i_item.command) inside
            sfts_pkg::CMD_WRITE, sfts_pkg::CMD_READ, sfts_pkg::CMD_FAST: begin
                if (req_ok) begin
                    acc      = 1'b1;
                    n_cursor = sfts_pkg::COUNT_W'(i_item.flash_address);
                    n_buf    = i_item.buffer_address;
                    n_left   = i_item.byte_count;
                    n_chunk  = '0;
                    n_stamp  = i_item.now_ms;
                    if (!link_ready) begin
                        if (i_item.command == sfts_pkg::CMD_WRITE) begin
                            n_phase = sfts_pkg::PH_WPEND;
                        end else if (i_item.command == sfts_pkg::CMD_READ) begin
                            n_phase = sfts_pkg::PH_RPEND;
                        end else begin
                            n_phase = sfts_pkg::PH_FRPEND;
                        end
                    end else if (i_item.command == sfts_pkg::CMD_WRITE) begin
                        do_chunk = 1'b1;
                    end else begin
                        do_read  = 1'b1;
                        read_act = (i_item.command == sfts_pkg::CMD_READ)
                                   ? sfts_pkg::ACT_READ : sfts_pkg::ACT_FAST;
                    end
                end
            end
            sfts_pkg::CMD_POLL: begin
                unique case (r_phase) inside
                    sfts_pkg::PH_WPEND, sfts_pkg::PH_RPEND, sfts_pkg::PH_FRPEND: begin
                        if (link_ready) begin
                            if (r_phase == sfts_pkg::PH_WPEND) begin
                                do_chunk = 1'b1;
                            end else begin
                                do_read  = 1'b1;
                                read_act = (r_phase == sfts_pkg::PH_RPEND)
                                           ? sfts_pkg::ACT_READ : sfts_pkg::ACT_FAST;
                            end
                        end
                    end
                    sfts_pkg::PH_WAITTX: begin
                        if (!i_item.tx_busy) begin
                            n_stamp = i_item.now_ms;
                            n_phase = sfts_pkg::PH_WAITREADY;
                        end else begin
                            do_tmo = 1'b1;
                        end
                    end
                    sfts_pkg::PH_WAITRX: begin
                        if (!i_item.rx_busy) begin
                            n_stamp = i_item.now_ms;
                            n_left  = '0;
                            n_phase = sfts_pkg::PH_DONE;
                        end else begin
                            do_tmo = 1'b1;
                        end
                    end
                    sfts_pkg::PH_WAITREADY: begin
                        if (not_ready) begin
                            do_tmo = 1'b1;
                        end else begin
                            // advance past the programmed page
                            n_cursor = r_cursor + step_bytes;
                            n_buf    = r_buf + sfts_pkg::BADDR_W'(step_bytes);
                            n_left   = r_left - step_bytes;
                            n_chunk  = '0;
                            do_chunk = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sfts_pkg::CMD_ABORT: begin
                do_error = active;
            end
            default: begin
            end
        endcase

        if (do_tmo && timed_out) begin
            do_error = 1'b1;
        end

        if (do_chunk) begin
            n_stamp = i_item.now_ms;
            if (n_left == '0) begin
                n_chunk = '0;
                n_phase = sfts_pkg::PH_DONE;
            end else begin
                // cut at the next page boundary
                room  = sfts_pkg::CHUNK_W'(sfts_pkg::PAGE_BYTES)
                      - sfts_pkg::CHUNK_W'(n_cursor[sfts_pkg::PAGE_BITS-1:0]);
                chunk = (n_left > sfts_pkg::COUNT_W'(room))
                        ? room : n_left[sfts_pkg::CHUNK_W-1:0];
                n_chunk = chunk;
                n_phase = sfts_pkg::PH_WAITTX;
                act     = sfts_pkg::ACT_PROGRAM;
                res_fa  = n_cursor[sfts_pkg::FADDR_W-1:0];
                res_ba  = n_buf;
                res_len = sfts_pkg::LEN_W'(chunk);
            end
        end

        if (do_read) begin
            n_phase = sfts_pkg::PH_WAITRX;
            act     = read_act;
            res_fa  = n_cursor[sfts_pkg::FADDR_W-1:0];
            res_ba  = n_buf;
            res_len = n_left[sfts_pkg::LEN_W-1:0];
        end

        if (do_error) begin
            n_left  = '0;
            n_chunk = '0;
            n_stamp = i_item.now_ms;
            n_phase = sfts_pkg::PH_ERROR;
            act     = sfts_pkg::ACT_ABORT;
            res_fa  = '0;
            res_ba  = '0;
            res_len = '0;
        end

        o_result.accepted              = acc;
        o_result.phase                 = n_phase;
        o_result.action                = act;
        o_result.action_flash_address  = res_fa;
        o_result.action_buffer_address = res_ba;
        o_result.action_length         = res_len;
        o_result.done_res              = (n_phase == sfts_pkg::PH_DONE);
        o_result.error                 = (n_phase == sfts_pkg::PH_ERROR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sfts_pkg::PH_IDLE;
            r_cursor <= '0;
            r_left   <= '0;
            r_buf    <= '0;
            r_chunk  <= '0;
            r_stamp  <= '0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_cursor <= n_cursor;
            r_left   <= n_left;
            r_buf    <= n_buf;
            r_chunk  <= n_chunk;
            r_stamp  <= n_stamp;
        end
    end

`ifndef ASSERT_OFF
    a_abort_enters_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.command == sfts_pkg::CMD_ABORT && active)
        |=> (r_phase == sfts_pkg::PH_ERROR))
        else $error("abort while active did not enter error");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_phase) && $stable(r_left) && $stable(r_cursor)))
        else $error("transfer state changed without a transaction");

    a_chunk_only_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chunk != '0)
        |-> (r_phase == sfts_pkg::PH_WAITTX || r_phase == sfts_pkg::PH_WAITREADY))
        else $error("chunk size left over outside a page program");

    a_chunk_fits_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sfts_pkg::PH_WAITTX)
        |-> (r_chunk != '0
             && r_chunk <= sfts_pkg::CHUNK_W'(sfts_pkg::PAGE_BYTES)))
        else $error("page program chunk out of range");
`endif

endmodule

// ===== rtl/spi_flash_transfer_sequencer_top.sv =====
// SPI flash transfer sequencer, top level: ports, wait limit register,
// result register. Depends on sfts_pkg, sfts_in_stage and sfts_core.
//
// Usage:
//   Event channel (i_in_valid / o_in_stall): one transaction per request,
//   poll or SPI error item, taken when valid is high and stall is low.
//   Result channel (o_out_valid / i_out_stall): exactly one result per
//   event, in order, taken when valid is high and stall is low.
//   Config channel (i_cfg_valid / o_cfg_ready): writes the wait limit in ms;
//   ready is always high. Write it only while no event is in flight.
//   An event that is taken goes through the input register, then the result
//   register. Throughput: one event per cycle while the receiver does not
//   stall; the whole step is one pass of compare-and-update logic on the state.
//   Stall: the result register holds while the receiver stalls, the input
//   register still takes one more event, then o_in_stall rises.
//   Reset: phase idle, cursors cleared, wait limit back to 1000 ms.
module spi_flash_transfer_sequencer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sfts_pkg::CMD_W-1:0]    i_command,
    input  logic [sfts_pkg::FADDR_W-1:0]  i_flash_address,
    input  logic [sfts_pkg::COUNT_W-1:0]  i_byte_count,
    input  logic [sfts_pkg::BADDR_W-1:0]  i_buffer_address,
    input  logic                          i_flash_busy,
    input  logic                          i_status_valid,
    input  logic                          i_tx_busy,
    input  logic                          i_rx_busy,
    input  logic [sfts_pkg::TIME_W-1:0]   i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic [sfts_pkg::PHASE_W-1:0]  o_phase,
    output logic [sfts_pkg::ACTION_W-1:0] o_action,
    output logic [sfts_pkg::FADDR_W-1:0]  o_action_flash_address,
    output logic [sfts_pkg::BADDR_W-1:0]  o_action_buffer_address,
    output logic [sfts_pkg::LEN_W-1:0]    o_action_length,
    output logic                          o_done_res,
    output logic                          o_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfts_pkg::TMO_W-1:0]    i_cfg_data
);

    sfts_pkg::t_item              in_item;
    sfts_pkg::t_item              held_item;
    sfts_pkg::t_result            step_result;
    sfts_pkg::t_result            r_out;
    logic                         r_out_valid;
    logic                         held_valid;
    logic                         adv;
    logic [sfts_pkg::TMO_W-1:0]   r_wait_limit;

    assign in_item.command        = i_command;
    assign in_item.flash_address  = i_flash_address;
    assign in_item.byte_count     = i_byte_count;
    assign in_item.buffer_address = i_buffer_address;
    assign in_item.flash_busy     = i_flash_busy;
    assign in_item.status_valid   = i_status_valid;
    assign in_item.tx_busy        = i_tx_busy;
    assign in_item.rx_busy        = i_rx_busy;
    assign in_item.now_ms         = i_now_ms;

    // advance when an event is held and the result register is empty or being drained
    assign adv = held_valid && (!r_out_valid || !i_out_stall);

    sfts_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_stall (o_in_stall),
        .i_adv   (adv),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    sfts_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_item       (held_item),
        .i_wait_limit (r_wait_limit),
        .o_result     (step_result)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_limit <= sfts_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wait_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_accepted              = r_out.accepted;
    assign o_phase                 = r_out.phase;
    assign o_action                = r_out.action;
    assign o_action_flash_address  = r_out.action_flash_address;
    assign o_action_buffer_address = r_out.action_buffer_address;
    assign o_action_length         = r_out.action_length;
    assign o_done_res              = r_out.done_res;
    assign o_error                 = r_out.error;

endmodule
